FILE: hdl/sbe_pkg.sv
`timescale 1ns / 1ps
package sbe_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int MAX_VARS_DEF    = 16;
    localparam int WORD_W          = 32;

    localparam logic [7:0] OP_NOOP    = 8'd0;
    localparam logic [7:0] OP_ADD     = 8'd1;
    localparam logic [7:0] OP_SUB     = 8'd2;
    localparam logic [7:0] OP_MUL     = 8'd3;
    localparam logic [7:0] OP_DIV     = 8'd4;
    localparam logic [7:0] OP_MOD     = 8'd5;
    localparam logic [7:0] OP_AND     = 8'd6;
    localparam logic [7:0] OP_OR      = 8'd7;
    localparam logic [7:0] OP_XOR     = 8'd8;
    localparam logic [7:0] OP_RSH     = 8'd9;
    localparam logic [7:0] OP_LSH     = 8'd10;
    localparam logic [7:0] OP_PUSH    = 8'd11;
    localparam logic [7:0] OP_POP     = 8'd12;
    localparam logic [7:0] OP_LOAD    = 8'd13;
    localparam logic [7:0] OP_STORE   = 8'd14;
    localparam logic [7:0] OP_GPIOIN  = 8'd15;
    localparam logic [7:0] OP_GPIOOUT = 8'd16;
    localparam logic [7:0] OP_PRINT   = 8'd17;
    localparam logic [7:0] OP_RETURN  = 8'd18;
    localparam logic [7:0] OP_SLEEP   = 8'd19;

    localparam logic [3:0] K_OK      = 4'd0;
    localparam logic [3:0] K_EMPTY   = 4'd1;
    localparam logic [3:0] K_FULL    = 4'd2;
    localparam logic [3:0] K_DIVZ    = 4'd3;
    localparam logic [3:0] K_INDEX   = 4'd4;
    localparam logic [3:0] K_UNKNOWN = 4'd5;
    localparam logic [3:0] K_GPIO    = 4'd6;
    localparam logic [3:0] K_SLEEP   = 4'd7;
    localparam logic [3:0] K_CHAR    = 4'd8;
    localparam logic [3:0] K_RET     = 4'd9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_WAIT_B,
        ST_EXEC,
        ST_DIV,
        ST_DIV_FIX,
        ST_PUSH,
        ST_PRINT_RD,
        ST_PRINT_OUT,
        ST_CLEAR,
        ST_OUT
    } state_t;

endpackage

FILE: hdl/sbe_ram.sv
`timescale 1ns / 1ps
module sbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/sbe_divider.sv
`timescale 1ns / 1ps
module sbe_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [32:0] trial;

    assign trial = {r_reg, q_reg[31]} - {1'b0, d_reg};

    always_comb begin
        cnt_next = cnt_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        if (start) begin
            cnt_next = 6'd32;
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
        end else if (cnt_reg != 6'd0) begin
            cnt_next = cnt_reg - 6'd1;
            if (!trial[32]) begin
                r_next = trial[31:0];
                q_next = {q_reg[30:0], 1'b1};
            end else begin
                r_next = {r_reg[30:0], q_reg[31]};
                q_next = {q_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy      = (cnt_reg != 6'd0);
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

FILE: hdl/stack_bytecode_executor.sv
`timescale 1ns / 1ps
// Executes one stack-machine instruction per input beat. The s_ channel carries
// opcode, operand and pin_level; the m_ channel returns kind, value, pin and last,
// one or more beats per instruction, the final one with m_last set.
// The cfg channel writes num_vars, the number of usable local variable slots;
// write it only while the block is idle.
// s_ready is high only while the block is idle, so instructions run one at a time.
// Each instruction steps through the state machine from accept to its result, with
// stack operands read through the registered read port of the stack RAM. DIV and
// MOD also wait on the radix-2 divider. PRINT reads and emits each character popped.
// Errors and RETURN clear the local variables at once and reset the stack count.
// After reset the stack is empty, all variables read 0 and num_vars is 0.
// A result beat is held in an output register until m_ready takes it; the block
// waits there, so a stalled receiver simply stalls the next instruction.
module stack_bytecode_executor #(
    parameter int STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF,
    parameter int MAX_VARS    = sbe_pkg::MAX_VARS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_opcode,
    input  logic [7:0]         s_operand,
    input  logic               s_pin_level,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_kind,
    output logic signed [31:0] m_value,
    output logic [7:0]         m_pin,
    output logic               m_last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [4:0]         cfg_data
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int VW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int LW = $clog2(MAX_VARS + 1);

    sbe_pkg::state_t state_reg, state_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    op_reg, op_next;
    logic [7:0]    imm_reg, imm_next;
    logic          lvl_reg, lvl_next;
    logic [31:0]   a_reg, a_next;
    logic [31:0]   b_reg, b_next;
    logic [31:0]   r_reg, r_next;
    logic [4:0]    nv_reg;
    logic [31:0]   vars_reg [MAX_VARS];
    logic [MAX_VARS-1:0] vvalid_reg, vvalid_next;
    logic          vwe;
    logic [VW-1:0] vidx;

    logic [3:0]    okind_reg, okind_next;
    logic [31:0]   oval_reg, oval_next;
    logic [7:0]    opin_reg, opin_next;
    logic          olast_reg, olast_next;
    logic          top_reg, top_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;

    logic          div_start, div_busy;
    logic [31:0]   div_q, div_r;

    logic [LW-1:0] limit;
    logic          idx_bad;
    logic [31:0]   alu;
    logic [31:0]   var_rd;

    sbe_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sbe_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (b_reg[31] ? (32'd0 - b_reg) : b_reg),
        .divisor   (a_reg[31] ? (32'd0 - a_reg) : a_reg),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign limit = ({27'd0, nv_reg} < 32'(MAX_VARS)) ? LW'(nv_reg) : LW'(MAX_VARS);
    assign idx_bad = ({1'b0, imm_reg} >= 9'(limit));
    assign vidx = VW'(imm_reg);
    assign var_rd = vvalid_reg[vidx] ? vars_reg[vidx] : 32'd0;

    always_comb begin
        case (op_reg)
            sbe_pkg::OP_ADD: alu = b_reg + a_reg;
            sbe_pkg::OP_SUB: alu = b_reg - a_reg;
            sbe_pkg::OP_MUL: alu = b_reg * a_reg;
            sbe_pkg::OP_AND: alu = b_reg & a_reg;
            sbe_pkg::OP_OR:  alu = b_reg | a_reg;
            sbe_pkg::OP_XOR: alu = b_reg ^ a_reg;
            sbe_pkg::OP_RSH: alu = 32'($signed(b_reg) >>> a_reg[4:0]);
            sbe_pkg::OP_LSH: alu = b_reg << a_reg[4:0];
            default:         alu = 32'd0;
        endcase
    end

    assign ram_raddr = AW'(cnt_reg - CW'(1));

    // Next state and datapath.
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        imm_next    = imm_reg;
        lvl_next    = lvl_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        r_next      = r_reg;
        vvalid_next = vvalid_reg;
        okind_next  = okind_reg;
        oval_next   = oval_reg;
        opin_next   = opin_reg;
        olast_next  = olast_reg;
        top_next    = top_reg;
        ram_we      = 1'b0;
        ram_waddr   = AW'(cnt_reg);
        ram_wdata   = r_reg;
        div_start   = 1'b0;
        vwe         = 1'b0;
        case (state_reg)
            sbe_pkg::ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_opcode;
                    imm_next   = s_operand;
                    lvl_next   = s_pin_level;
                    opin_next  = 8'd0;
                    olast_next = 1'b1;
                    top_next   = 1'b0;
                    state_next = sbe_pkg::ST_RD_A;
                end
            end
            sbe_pkg::ST_RD_A: begin
                // Decode; the RAM is reading the current top.
                state_next = sbe_pkg::ST_OUT;
                okind_next = sbe_pkg::K_OK;
                oval_next  = 32'd0;
                top_next   = 1'b1;
                if (op_reg >= sbe_pkg::OP_ADD && op_reg <= sbe_pkg::OP_LSH) begin
                    top_next = 1'b0;
                    if (cnt_reg < CW'(2)) begin
                        okind_next = sbe_pkg::K_EMPTY;
                        state_next = sbe_pkg::ST_CLEAR;
                    end else begin
                        cnt_next   = cnt_reg - CW'(1);
                        state_next = sbe_pkg::ST_RD_B;
                    end
                end else begin
                    case (op_reg)
                        sbe_pkg::OP_NOOP: ;
                        sbe_pkg::OP_PUSH, sbe_pkg::OP_GPIOIN, sbe_pkg::OP_LOAD: begin
                            top_next = 1'b0;
                            r_next = (op_reg == sbe_pkg::OP_PUSH) ? {24'd0, imm_reg} :
                                     (op_reg == sbe_pkg::OP_GPIOIN) ? {31'd0, lvl_reg} :
                                     var_rd;
                            if (op_reg == sbe_pkg::OP_LOAD && idx_bad) begin
                                okind_next = sbe_pkg::K_INDEX;
                                state_next = sbe_pkg::ST_CLEAR;
                            end else if (cnt_reg >= CW'(STACK_DEPTH)) begin
                                okind_next = sbe_pkg::K_FULL;
                                state_next = sbe_pkg::ST_CLEAR;
                            end else begin
                                state_next = sbe_pkg::ST_PUSH;
                            end
                        end
                        sbe_pkg::OP_STORE: begin
                            if (idx_bad) begin
                                okind_next = sbe_pkg::K_INDEX;
                                top_next   = 1'b0;
                                state_next = sbe_pkg::ST_CLEAR;
                            end else if (cnt_reg == CW'(0)) begin
                                okind_next = sbe_pkg::K_EMPTY;
                                top_next   = 1'b0;
                                state_next = sbe_pkg::ST_CLEAR;
                            end else begin
                                cnt_next   = cnt_reg - CW'(1);
                                state_next = sbe_pkg::ST_WAIT_B;
                            end
                        end
                        sbe_pkg::OP_POP, sbe_pkg::OP_GPIOOUT, sbe_pkg::OP_RETURN,
                        sbe_pkg::OP_SLEEP: begin
                            if (cnt_reg == CW'(0)) begin
                                okind_next = sbe_pkg::K_EMPTY;
                                top_next   = 1'b0;
                                state_next = sbe_pkg::ST_CLEAR;
                            end else begin
                                cnt_next   = cnt_reg - CW'(1);
                                state_next = sbe_pkg::ST_WAIT_B;
                            end
                        end
                        sbe_pkg::OP_PRINT: begin
                            top_next = 1'b0;
                            if (cnt_reg == CW'(0)) begin
                                state_next = sbe_pkg::ST_OUT;
                            end else begin
                                cnt_next   = cnt_reg - CW'(1);
                                state_next = sbe_pkg::ST_PRINT_RD;
                            end
                        end
                        default: begin
                            okind_next = sbe_pkg::K_UNKNOWN;
                            top_next   = 1'b0;
                            state_next = sbe_pkg::ST_CLEAR;
                        end
                    endcase
                end
            end
            sbe_pkg::ST_RD_B: begin
                a_next     = ram_rdata;
                state_next = sbe_pkg::ST_WAIT_B;
            end
            sbe_pkg::ST_WAIT_B: begin
                // Popped word for unary pops, or b for binary operations.
                top_next = 1'b0;
                if (op_reg >= sbe_pkg::OP_ADD && op_reg <= sbe_pkg::OP_LSH) begin
                    b_next     = ram_rdata;
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = sbe_pkg::ST_EXEC;
                end else begin
                    a_next     = ram_rdata;
                    state_next = sbe_pkg::ST_OUT;
                    case (op_reg)
                        sbe_pkg::OP_POP: begin
                            top_next   = 1'b1;
                        end
                        sbe_pkg::OP_STORE: begin
                            vwe        = 1'b1;
                            top_next   = 1'b1;
                            vvalid_next[vidx] = 1'b1;
                        end
                        sbe_pkg::OP_GPIOOUT: begin
                            okind_next = sbe_pkg::K_GPIO;
                            oval_next  = {31'd0, ram_rdata != 32'd0};
                            opin_next  = imm_reg;
                        end
                        sbe_pkg::OP_SLEEP: begin
                            okind_next = sbe_pkg::K_SLEEP;
                            oval_next  = ram_rdata;
                        end
                        default: begin
                            okind_next  = sbe_pkg::K_RET;
                            oval_next   = ram_rdata;
                            cnt_next    = '0;
                            vvalid_next = '0;
                        end
                    endcase
                end
            end
            sbe_pkg::ST_EXEC: begin
                if (op_reg == sbe_pkg::OP_DIV || op_reg == sbe_pkg::OP_MOD) begin
                    if (a_reg == 32'd0) begin
                        okind_next = sbe_pkg::K_DIVZ;
                        state_next = sbe_pkg::ST_CLEAR;
                    end else begin
                        div_start  = 1'b1;
                        state_next = sbe_pkg::ST_DIV;
                    end
                end else begin
                    r_next     = alu;
                    state_next = sbe_pkg::ST_PUSH;
                end
            end
            sbe_pkg::ST_DIV: begin
                if (!div_busy) begin
                    state_next = sbe_pkg::ST_DIV_FIX;
                end
            end
            sbe_pkg::ST_DIV_FIX: begin
                if (op_reg == sbe_pkg::OP_DIV) begin
                    r_next = (a_reg[31] ^ b_reg[31]) ? (32'd0 - div_q) : div_q;
                end else begin
                    r_next = b_reg[31] ? (32'd0 - div_r) : div_r;
                end
                state_next = sbe_pkg::ST_PUSH;
            end
            sbe_pkg::ST_PUSH: begin
                ram_we     = 1'b1;
                cnt_next   = cnt_reg + CW'(1);
                okind_next = sbe_pkg::K_OK;
                oval_next  = r_reg;
                top_next   = 1'b0;
                state_next = sbe_pkg::ST_OUT;
            end
            sbe_pkg::ST_PRINT_RD: begin
                a_next     = ram_rdata;
                state_next = sbe_pkg::ST_PRINT_OUT;
            end
            sbe_pkg::ST_PRINT_OUT: begin
                okind_next = sbe_pkg::K_CHAR;
                oval_next  = {24'd0, a_reg[7:0]};
                olast_next = (a_reg[7:0] == 8'd0) || (cnt_reg == CW'(0));
                state_next = sbe_pkg::ST_OUT;
            end
            sbe_pkg::ST_CLEAR: begin
                cnt_next    = '0;
                vvalid_next = '0;
                oval_next   = 32'd0;
                top_next    = 1'b0;
                state_next  = sbe_pkg::ST_OUT;
            end
            sbe_pkg::ST_OUT: begin
                top_next = 1'b0;
                if (top_reg) begin
                    oval_next = (cnt_reg == CW'(0)) ? 32'd0 : ram_rdata;
                end else if (m_ready) begin
                    if (olast_reg) begin
                        state_next = sbe_pkg::ST_IDLE;
                    end else begin
                        cnt_next   = cnt_reg - CW'(1);
                        state_next = sbe_pkg::ST_PRINT_RD;
                    end
                end
            end
            default: state_next = sbe_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        s_ready   = (state_reg == sbe_pkg::ST_IDLE);
        cfg_ready = (state_reg == sbe_pkg::ST_IDLE);
        m_valid   = (state_reg == sbe_pkg::ST_OUT) && !top_reg;
    end

    assign m_kind  = okind_reg;
    assign m_value = oval_reg;
    assign m_pin   = opin_reg;
    assign m_last  = olast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sbe_pkg::ST_IDLE;
            cnt_reg    <= '0;
            nv_reg     <= '0;
            vvalid_reg <= '0;
            top_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            vvalid_reg <= vvalid_next;
            top_reg    <= top_next;
            if (cfg_valid && cfg_ready) begin
                nv_reg <= cfg_data;
            end
        end
        op_reg    <= op_next;
        imm_reg   <= imm_next;
        lvl_reg   <= lvl_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        r_reg     <= r_next;
        okind_reg <= okind_next;
        oval_reg  <= oval_next;
        opin_reg  <= opin_next;
        olast_reg <= olast_next;
        if (vwe) begin
            vars_reg[vidx] <= a_next;
        end
    end

endmodule

FILE: verif/tb_stack_bytecode_executor.sv
`timescale 1ns / 1ps
module tb_stack_bytecode_executor;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] value;
        logic [7:0]  pin;
        logic        last;
    } beat_t;

    class exec_scoreboard;
        logic [31:0] stack_words [64];
        int          depth;
        logic [31:0] vars [16];
        logic [4:0]  num_vars;
        beat_t       expected_q [$];
        int          errors;

        function new();
            wipe();
            num_vars = 0;
            errors   = 0;
        endfunction

        function void wipe();
            depth = 0;
            foreach (vars[i]) vars[i] = '0;
        endfunction

        function void emit(logic [3:0] kind, logic [31:0] value, logic [7:0] pin, logic last);
            beat_t b;
            b.kind  = kind;
            b.value = value;
            b.pin   = pin;
            b.last  = last;
            expected_q.push_back(b);
        endfunction

        function void abort(logic [3:0] kind);
            wipe();
            emit(kind, '0, '0, 1'b1);
        endfunction

        function void emit_top();
            emit(sbe_pkg::K_OK, (depth > 0) ? stack_words[depth-1] : 32'd0, '0, 1'b1);
        endfunction

        function void note_instr(logic [7:0] op, logic [7:0] imm, logic lvl);
            logic [31:0] a, b, r, ua, ub, q, m;
            int          limit;
            int          n;
            logic [7:0]  c;
            limit = (num_vars < 16) ? num_vars : 16;
            if (op >= sbe_pkg::OP_ADD && op <= sbe_pkg::OP_LSH) begin
                if (depth < 2) begin
                    abort(sbe_pkg::K_EMPTY);
                    return;
                end
                a = stack_words[depth-1];
                b = stack_words[depth-2];
                depth -= 2;
                case (op)
                    sbe_pkg::OP_ADD: r = b + a;
                    sbe_pkg::OP_SUB: r = b - a;
                    sbe_pkg::OP_MUL: r = b * a;
                    sbe_pkg::OP_DIV, sbe_pkg::OP_MOD: begin
                        if (a == 0) begin
                            abort(sbe_pkg::K_DIVZ);
                            return;
                        end
                        ua = a[31] ? -a : a;
                        ub = b[31] ? -b : b;
                        q  = ub / ua;
                        m  = ub % ua;
                        if (op == sbe_pkg::OP_DIV) r = (a[31] ^ b[31]) ? -q : q;
                        else r = b[31] ? -m : m;
                    end
                    sbe_pkg::OP_AND: r = b & a;
                    sbe_pkg::OP_OR:  r = b | a;
                    sbe_pkg::OP_XOR: r = b ^ a;
                    sbe_pkg::OP_RSH: r = $signed(b) >>> a[4:0];
                    default: r = b << a[4:0];
                endcase
                stack_words[depth] = r;
                depth++;
                emit_top();
                return;
            end
            case (op)
                sbe_pkg::OP_NOOP: emit_top();
                sbe_pkg::OP_PUSH, sbe_pkg::OP_GPIOIN: begin
                    if (depth >= 64) abort(sbe_pkg::K_FULL);
                    else begin
                        stack_words[depth] = (op == sbe_pkg::OP_PUSH) ? {24'd0, imm}
                                                                      : {31'd0, lvl};
                        depth++;
                        emit_top();
                    end
                end
                sbe_pkg::OP_POP: begin
                    if (depth == 0) abort(sbe_pkg::K_EMPTY);
                    else begin
                        depth--;
                        emit_top();
                    end
                end
                sbe_pkg::OP_LOAD: begin
                    if (imm >= limit) abort(sbe_pkg::K_INDEX);
                    else if (depth >= 64) abort(sbe_pkg::K_FULL);
                    else begin
                        stack_words[depth] = vars[imm[3:0]];
                        depth++;
                        emit_top();
                    end
                end
                sbe_pkg::OP_STORE: begin
                    if (imm >= limit) abort(sbe_pkg::K_INDEX);
                    else if (depth == 0) abort(sbe_pkg::K_EMPTY);
                    else begin
                        depth--;
                        vars[imm[3:0]] = stack_words[depth];
                        emit_top();
                    end
                end
                sbe_pkg::OP_GPIOOUT: begin
                    if (depth == 0) abort(sbe_pkg::K_EMPTY);
                    else begin
                        depth--;
                        emit(sbe_pkg::K_GPIO, (stack_words[depth] != 0) ? 32'd1 : 32'd0,
                             imm, 1'b1);
                    end
                end
                sbe_pkg::OP_PRINT: begin
                    n = 0;
                    c = 8'hFF;
                    while (c != 0 && depth > 0) begin
                        depth--;
                        c = stack_words[depth][7:0];
                        emit(sbe_pkg::K_CHAR, {24'd0, c}, '0, 1'b0);
                        n++;
                    end
                    if (n == 0) emit_top();
                    else expected_q[$].last = 1'b1;
                end
                sbe_pkg::OP_RETURN, sbe_pkg::OP_SLEEP: begin
                    if (depth == 0) abort(sbe_pkg::K_EMPTY);
                    else begin
                        depth--;
                        r = stack_words[depth];
                        if (op == sbe_pkg::OP_RETURN) begin
                            wipe();
                            emit(sbe_pkg::K_RET, r, '0, 1'b1);
                        end else begin
                            emit(sbe_pkg::K_SLEEP, r, '0, 1'b1);
                        end
                    end
                end
                default: abort(sbe_pkg::K_UNKNOWN);
            endcase
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_beat(beat_t got);
            beat_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result beat kind=%0d value=%0h", got.kind,
                                 got.value));
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.value !== want.value)
                report($sformatf("value %0h, expected %0h", got.value, want.value));
            if (got.pin !== want.pin)
                report($sformatf("pin %0d, expected %0d", got.pin, want.pin));
            if (got.last !== want.last)
                report($sformatf("last %0b, expected %0b", got.last, want.last));
        endtask
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_opcode = '0;
    logic [7:0]         s_operand = '0;
    logic               s_pin_level = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [3:0]         m_kind;
    logic signed [31:0] m_value;
    logic [7:0]         m_pin;
    logic               m_last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [4:0]         cfg_data = '0;

    exec_scoreboard sb = new();
    bit             no_idle = 1'b0;
    bit             hold_req = 1'b0;
    int             quiet_cycles = 0;

    stack_bytecode_executor u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_operand(s_operand), .s_pin_level(s_pin_level),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind), .m_value(m_value),
        .m_pin(m_pin), .m_last(m_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 50) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    task automatic send_instr(logic [7:0] op, logic [7:0] imm, logic lvl);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_operand   <= imm;
        s_pin_level <= lvl;
        do @(posedge aclk); while (!s_ready);
        sb.note_instr(op, imm, lvl);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_num_vars(logic [4:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.num_vars = v;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_instr();
        int          r;
        logic [7:0]  imm;
        logic        lvl;
        r   = $urandom_range(0, 99);
        imm = 8'($urandom_range(0, 255));
        lvl = 1'($urandom_range(0, 1));
        if (r < 30) send_instr(sbe_pkg::OP_PUSH, imm, lvl);
        else if (r < 34) send_instr(sbe_pkg::OP_GPIOIN, imm, lvl);
        else if (r < 50) begin
            if ($urandom_range(0, 9) != 0) imm = 8'($urandom_range(0, 17));
            send_instr((r < 42) ? sbe_pkg::OP_LOAD : sbe_pkg::OP_STORE, imm, lvl);
        end
        else if (r < 72) send_instr(8'($urandom_range(1, 10)), imm, lvl);
        else if (r < 78) send_instr(sbe_pkg::OP_PRINT, imm, lvl);
        else if (r < 82) send_instr(sbe_pkg::OP_POP, imm, lvl);
        else if (r < 85) send_instr(sbe_pkg::OP_GPIOOUT, imm, lvl);
        else if (r < 88) send_instr(sbe_pkg::OP_SLEEP, imm, lvl);
        else if (r < 91) send_instr(sbe_pkg::OP_RETURN, imm, lvl);
        else if (r < 94) send_instr(sbe_pkg::OP_NOOP, imm, lvl);
        else send_instr(8'($urandom_range(20, 255)), imm, lvl);
    endtask

    initial begin
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_req = 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge aclk);
                end else if (r < 95) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(20, 60)) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_beat({m_kind, m_value, m_pin, m_last});
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [4:0] settings [6];
        settings = '{5'd16, 5'd31, 5'd5, 5'd0, 5'd1, 5'd0};
        settings[5] = 5'($urandom_range(0, 31));
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Edge cases run with the reset value of num_vars.
        send_instr(sbe_pkg::OP_NOOP, 8'd0, 1'b0);
        send_instr(sbe_pkg::OP_POP, 8'd0, 1'b0);
        send_instr(sbe_pkg::OP_PUSH, 8'd255, 1'b0);
        send_instr(sbe_pkg::OP_PUSH, 8'd0, 1'b0);
        send_instr(sbe_pkg::OP_DIV, 8'd0, 1'b0);
        send_instr(sbe_pkg::OP_PUSH, 8'd1, 1'b0);
        send_instr(sbe_pkg::OP_PUSH, 8'd31, 1'b0);
        send_instr(sbe_pkg::OP_LSH, 8'd0, 1'b0);
        send_instr(sbe_pkg::OP_PUSH, 8'd0, 1'b0);
        send_instr(sbe_pkg::OP_PUSH, 8'd1, 1'b0);
        send_instr(sbe_pkg::OP_SUB, 8'd0, 1'b0);
        send_instr(sbe_pkg::OP_DIV, 8'd0, 1'b0);
        send_instr(sbe_pkg::OP_PUSH, 8'd0, 1'b0);
        send_instr(sbe_pkg::OP_PUSH, 8'd1, 1'b0);
        send_instr(sbe_pkg::OP_SUB, 8'd0, 1'b0);
        send_instr(sbe_pkg::OP_MOD, 8'd0, 1'b0);
        send_instr(sbe_pkg::OP_STORE, 8'd0, 1'b0);
        send_instr(sbe_pkg::OP_GPIOIN, 8'd0, 1'b1);
        send_instr(sbe_pkg::OP_GPIOOUT, 8'd255, 1'b0);
        send_instr(sbe_pkg::OP_PUSH, 8'd3, 1'b0);
        send_instr(sbe_pkg::OP_SLEEP, 8'd0, 1'b0);
        send_instr(8'd255, 8'd0, 1'b0);
        send_instr(sbe_pkg::OP_PUSH, 8'd72, 1'b0);
        send_instr(sbe_pkg::OP_PUSH, 8'd5, 1'b0);
        send_instr(sbe_pkg::OP_RETURN, 8'd0, 1'b0);
        send_instr(sbe_pkg::OP_PRINT, 8'd0, 1'b0);
        send_instr(sbe_pkg::OP_PUSH, 8'd0, 1'b0);
        send_instr(sbe_pkg::OP_PUSH, 8'd65, 1'b0);
        send_instr(sbe_pkg::OP_PRINT, 8'd0, 1'b0);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_num_vars(settings[p]);
            no_idle  = (p == 3);
            hold_req = (p == 0);
            if (p == 1) begin
                for (int i = 0; i < 66; i++)
                    send_instr(sbe_pkg::OP_PUSH, 8'($urandom_range(0, 255)), 1'b0);
                send_instr(sbe_pkg::OP_LOAD, 8'd15, 1'b0);
            end
            repeat (28) random_instr();
            drain();
        end

        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

FILE: stack_bytecode_executor.f
hdl/sbe_pkg.sv
hdl/sbe_ram.sv
hdl/sbe_divider.sv
hdl/stack_bytecode_executor.sv
verif/tb_stack_bytecode_executor.sv
